### rtl/circular_deque_unit_defines.svh
// assertion macros shared by the deque rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/cdq_pkg.sv
// shared types, widths and operation codes for the circular deque
// no dependencies; used by the interfaces, the top level and the core
package cdq_pkg;

    localparam int DefaultDepth = 16;
    localparam int DataWidth    = 32;
    localparam int ModeWidth    = 3;
    localparam int CapWidth     = 5;

    localparam logic [CapWidth-1:0] CapacityReset = 5'd16;

    // operation codes; the remaining codes are refused
    localparam logic [ModeWidth-1:0] ModePushFront = 3'd0;
    localparam logic [ModeWidth-1:0] ModePushRear  = 3'd1;
    localparam logic [ModeWidth-1:0] ModePopFront  = 3'd2;
    localparam logic [ModeWidth-1:0] ModePopRear   = 3'd3;
    localparam logic [ModeWidth-1:0] ModeNop       = 3'd4;

    localparam logic signed [DataWidth-1:0] EmptyValue = -32'sd1;

    typedef struct packed {
        logic                        accepted;
        logic signed [DataWidth-1:0] front_value;
        logic signed [DataWidth-1:0] rear_value;
        logic                        is_empty;
        logic                        is_full;
    } t_result;

endpackage

### rtl/cdq_ifs.sv
// valid/ready channel interfaces of the circular deque
// depends on cdq_pkg for field widths
interface cdq_in_if;
    import cdq_pkg::*;
    logic                        valid;
    logic                        ready;
    logic [ModeWidth-1:0]        mode;
    logic signed [DataWidth-1:0] value;
    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface cdq_out_if;
    import cdq_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic signed [DataWidth-1:0] front_value;
    logic signed [DataWidth-1:0] rear_value;
    logic                        is_empty;
    logic                        is_full;
    modport source (output valid, output accepted, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input accepted, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

interface cdq_cfg_if;
    import cdq_pkg::*;
    logic                valid;
    logic                ready;
    logic [CapWidth-1:0] capacity;
    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

### rtl/circular_deque_unit.sv
// top level of the circular deque: input register, deque core, result register
// depends on cdq_pkg, cdq_ifs, cdq_core and circular_deque_unit_defines.svh
//
//  channel   dir   payload                                            transfer when
//  i_item    in    mode, value                                        valid && ready
//  o_result  out   accepted, front_value, rear_value, is_empty,       valid && ready
//                  is_full
//  i_cfg     in    capacity                                           valid (ready tied high)
//
// one item per cycle sustained while the result is taken; each item passes the input register
// and the core, and its result is loaded into the result register, which raises valid
// the entry ram reads the neighbors of the next front and rear every cycle, so a pop
// finds its new end value already registered
// synchronous active-low reset empties the deque and restores capacity 16 (clamped)
// a stalled result holds the core; the input register then fills and drops ready
`include "circular_deque_unit_defines.svh"

module circular_deque_unit #(
    parameter int DEPTH = cdq_pkg::DefaultDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdq_in_if.sink      i_item,
    cdq_out_if.source   o_result,
    cdq_cfg_if.sink     i_cfg
);
    import cdq_pkg::*;

    // input register
    logic                        r_in_valid;
    logic [ModeWidth-1:0]        r_in_mode;
    logic signed [DataWidth-1:0] r_in_value;

    // result register
    logic    r_out_valid;
    t_result r_out;

    logic    exec;
    t_result core_result;

    // the core runs when an item waits and the result slot is free or draining
    assign exec         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || exec;
    assign i_cfg.ready  = 1'b1;

    cdq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_exec     (exec),
        .i_mode     (r_in_mode),
        .i_value    (r_in_value),
        .i_cfg_we   (i_cfg.valid),
        .i_capacity (i_cfg.capacity),
        .o_result   (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_mode  <= i_item.mode;
            r_in_value <= i_item.value;
        end
        if (exec) begin
            r_out <= core_result;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.accepted    = r_out.accepted;
    assign o_result.front_value = r_out.front_value;
    assign o_result.rear_value  = r_out.rear_value;
    assign o_result.is_empty    = r_out.is_empty;
    assign o_result.is_full     = r_out.is_full;

    // a waiting item is never dropped while the core is held
    `CDQ_ASSERT_NEXT(a_in_held, i_clk, i_rst_n,
        r_in_valid && !exec, r_in_valid, "input item lost while stalled")
    // every core step lands in the result register
    `CDQ_ASSERT_NEXT(a_exec_loads, i_clk, i_rst_n,
        exec, r_out_valid, "core step produced no result")
    // an empty deque reports -1 at both ends
    `CDQ_ASSERT_NOW(a_empty_vals, i_clk, i_rst_n,
        r_out_valid && r_out.is_empty,
        (r_out.front_value == EmptyValue) && (r_out.rear_value == EmptyValue),
        "empty result with end values other than -1")
    // empty and full never together
    `CDQ_ASSERT_NOW(a_empty_not_full, i_clk, i_rst_n,
        r_out_valid, !(r_out.is_empty && r_out.is_full), "result flagged both empty and full")

endmodule

### rtl/cdq_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

### rtl/cdq_core.sv
// deque state: ring indices, cached end values, entry ram and neighbor prefetch
// depends on cdq_pkg and cdq_ram
module cdq_core #(
    parameter int DEPTH = cdq_pkg::DefaultDepth
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_exec,
    input  logic [cdq_pkg::ModeWidth-1:0]       i_mode,
    input  logic signed [cdq_pkg::DataWidth-1:0] i_value,
    input  logic                                i_cfg_we,
    input  logic [cdq_pkg::CapWidth-1:0]        i_capacity,
    output cdq_pkg::t_result                    o_result
);
    import cdq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // clamp capacity to 1..DEPTH and return the last slot index in use
    function automatic logic [IW-1:0] cap_last(input logic [CapWidth-1:0] cap);
        int unsigned c;
        c = int'(cap);
        if (c == 0) begin
            c = 1;
        end
        if (c > DEPTH) begin
            c = DEPTH;
        end
        return IW'(c - 1);
    endfunction

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i,
                                                input logic [IW-1:0] last);
        return (i == last) ? '0 : IW'(i + 1'b1);
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i,
                                                input logic [IW-1:0] last);
        return (i == '0) ? last : IW'(i - 1'b1);
    endfunction

    logic [IW-1:0]              r_front, n_front;
    logic [IW-1:0]              r_rear, n_rear;
    logic                       r_empty, n_empty;
    logic [IW-1:0]              r_last, n_last;
    logic signed [DataWidth-1:0] r_front_val, n_front_val;
    logic signed [DataWidth-1:0] r_rear_val, n_rear_val;

    // write-first bypass for the prefetched neighbors
    logic                 r_fn_byp, r_rp_byp;
    logic [DataWidth-1:0] r_wdata_q;

    logic                 we;
    logic [IW-1:0]        waddr;
    logic [IW-1:0]        raddr_fn, raddr_rp;
    logic [DataWidth-1:0] rd_fn, rd_rp;
    logic signed [DataWidth-1:0] nb_front, nb_rear;
    logic                 full_now;
    logic                 accepted;

    cdq_ram #(
        .WIDTH (DataWidth),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_value),
        .i_raddr_a (raddr_fn),
        .i_raddr_b (raddr_rp),
        .o_rdata_a (rd_fn),
        .o_rdata_b (rd_rp)
    );

    // entry behind the front and entry ahead of the rear
    assign nb_front = r_fn_byp ? r_wdata_q : rd_fn;
    assign nb_rear  = r_rp_byp ? r_wdata_q : rd_rp;
    assign full_now = !r_empty && (ring_next(r_rear, r_last) == r_front);

    always_comb begin
        n_front     = r_front;
        n_rear      = r_rear;
        n_empty     = r_empty;
        n_last      = r_last;
        n_front_val = r_front_val;
        n_rear_val  = r_rear_val;
        we          = 1'b0;
        waddr       = '0;
        accepted    = 1'b0;
        if (i_cfg_we) begin
            n_front = '0;
            n_rear  = '0;
            n_empty = 1'b1;
            n_last  = cap_last(i_capacity);
        end else if (i_exec) begin
            case (i_mode)
                ModePushFront, ModePushRear: begin
                    if (!full_now) begin
                        accepted = 1'b1;
                        we       = 1'b1;
                        if (r_empty) begin
                            n_front     = '0;
                            n_rear      = '0;
                            n_empty     = 1'b0;
                            n_front_val = i_value;
                            n_rear_val  = i_value;
                        end else if (i_mode == ModePushFront) begin
                            n_front     = ring_prev(r_front, r_last);
                            waddr       = n_front;
                            n_front_val = i_value;
                        end else begin
                            n_rear     = ring_next(r_rear, r_last);
                            waddr      = n_rear;
                            n_rear_val = i_value;
                        end
                    end
                end
                ModePopFront, ModePopRear: begin
                    if (!r_empty) begin
                        accepted = 1'b1;
                        if (r_front == r_rear) begin
                            n_front = '0;
                            n_rear  = '0;
                            n_empty = 1'b1;
                        end else if (i_mode == ModePopFront) begin
                            n_front     = ring_next(r_front, r_last);
                            n_front_val = nb_front;
                        end else begin
                            n_rear     = ring_prev(r_rear, r_last);
                            n_rear_val = nb_rear;
                        end
                    end
                end
                ModeNop: begin
                    accepted = 1'b1;
                end
                default: begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    // prefetch neighbors of the state that holds after this cycle
    assign raddr_fn = ring_next(n_front, n_last);
    assign raddr_rp = ring_prev(n_rear, n_last);

    always_comb begin
        o_result.accepted    = accepted;
        o_result.is_empty    = n_empty;
        o_result.front_value = n_empty ? EmptyValue : n_front_val;
        o_result.rear_value  = n_empty ? EmptyValue : n_rear_val;
        o_result.is_full     = !n_empty && (ring_next(n_rear, n_last) == n_front);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_rear   <= '0;
            r_empty  <= 1'b1;
            r_last   <= cap_last(CapacityReset);
            r_fn_byp <= 1'b0;
            r_rp_byp <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_empty  <= n_empty;
            r_last   <= n_last;
            r_fn_byp <= we && (waddr == raddr_fn);
            r_rp_byp <= we && (waddr == raddr_rp);
        end
    end

    always_ff @(posedge i_clk) begin
        r_front_val <= n_front_val;
        r_rear_val  <= n_rear_val;
        r_wdata_q   <= i_value;
    end

endmodule
